@@ design/spss_pkg.sv @@
// Shared types and constants for the servo pulse generator and sensor sampler.
// No dependencies; every other file imports this package.
`timescale 1ns / 1ps

package spss_pkg;

    localparam int CHANNELS_DEF     = 13;
    localparam int SAMPLE_DEPTH_DEF = 20;
    localparam int PWM_W            = 13;

    localparam logic [7:0] TICKS_RESET  = 8'd95;
    localparam logic [7:0] SLICES_RESET = 8'd10;
    localparam logic [4:0] THRESH_RESET = 5'd17;
    localparam logic [7:0] CENTER_WIDTH = 8'd47;

    typedef enum logic [1:0] {
        MODE_TICK  = 2'd0,
        MODE_WIDTH = 2'd1,
        MODE_WAIT  = 2'd2
    } mode_t;

    typedef enum logic [1:0] {
        REG_TICKS  = 2'd0,
        REG_SLICES = 2'd1,
        REG_THRESH = 2'd2
    } reg_index_t;

    typedef struct packed {
        logic [1:0] mode;
        logic [3:0] channel;
        logic [7:0] pulse_width;
        logic [7:0] wait_ticks;
        logic       right_level;
        logic       left_level;
    } in_item_t;

    typedef struct packed {
        logic [PWM_W-1:0] pwm_lines;
        logic             wait_active;
        logic             obstacle_right;
        logic             obstacle_left;
    } out_item_t;

endpackage

@@ design/spss_if.sv @@
// Handshake interfaces for the item, result and configuration channels.
// Depends on spss_pkg for the payload types.
`timescale 1ns / 1ps

interface spss_in_if
    import spss_pkg::*;
();
    logic     valid;
    logic     ready;
    in_item_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface spss_out_if
    import spss_pkg::*;
();
    logic      valid;
    logic      ready;
    out_item_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface spss_cfg_if;
    logic       valid;
    logic       ready;
    logic [1:0] reg_index;
    logic [7:0] wdata;

    modport source (output valid, output reg_index, output wdata, input ready);
    modport sink (input valid, input reg_index, input wdata, output ready);
endinterface

@@ design/spss_sensor_ring.sv @@
// Sample line for one active-low sensor with a running count of zero samples.
// Depends on spss_pkg (wildcard import only).
`timescale 1ns / 1ps

module spss_sensor_ring
    import spss_pkg::*;
#(
    parameter int DEPTH = SAMPLE_DEPTH_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       shift_en,
    input  logic       level,
    input  logic [4:0] threshold,
    output logic       blocked
);

    localparam int ZW = $clog2(DEPTH + 1);
    localparam int CW = (ZW > 5) ? ZW : 5;

    logic [DEPTH-1:0] ring_reg;
    logic [DEPTH-1:0] ring_next;
    logic [ZW-1:0]    zero_reg;
    logic [ZW-1:0]    zero_next;

    // oldest sample leaves at the top tap as the new one enters
    always_comb
    begin
        ring_next = ring_reg;
        zero_next = zero_reg;
        if (shift_en)
        begin
            ring_next = {ring_reg[DEPTH-2:0], level};
            zero_next = zero_reg + ZW'(!level) - ZW'(!ring_reg[DEPTH-1]);
        end
    end

    assign blocked = CW'(zero_next) > CW'(threshold);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ring_reg <= '1;
            zero_reg <= '0;
        end
        else
        begin
            ring_reg <= ring_next;
            zero_reg <= zero_next;
        end
    end

endmodule

@@ design/spss_skid.sv @@
// Two-entry output register for results: main stage plus skid stage.
// Depends on spss_pkg and spss_out_if.
`timescale 1ns / 1ps

module spss_skid
    import spss_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push_valid,
    input  out_item_t  push_data,
    output logic       push_ready,
    spss_out_if.source out_ch
);

    logic      main_valid_reg;
    logic      skid_valid_reg;
    out_item_t main_data_reg;
    out_item_t skid_data_reg;
    logic      push;
    logic      pop;

    assign push_ready   = !skid_valid_reg;
    assign push         = push_valid && push_ready;
    assign pop          = main_valid_reg && out_ch.ready;
    assign out_ch.valid = main_valid_reg;
    assign out_ch.data  = main_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (pop || !main_valid_reg)
        begin
            if (skid_valid_reg)
            begin
                main_valid_reg <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
            else
            begin
                main_valid_reg <= push;
            end
        end
        else if (push)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop || !main_valid_reg)
        begin
            main_data_reg <= skid_valid_reg ? skid_data_reg : push_data;
        end
        else if (push)
        begin
            skid_data_reg <= push_data;
        end
    end

endmodule

@@ design/servo_pwm_and_sensor_sampler_top.sv @@
// Top level: servo pulse timing, wait counter, sensor rings and result buffer.
// Depends on spss_pkg, spss_if, spss_sensor_ring and spss_skid.
//
//  channel     | dir | payload                                   | transfer when
//  ------------+-----+-------------------------------------------+------------------
//  item_in     | in  | mode, channel, pulse_width, wait_ticks,   | valid && ready
//              |     | right_level, left_level                   |
//  result_out  | out | pwm_lines, wait_active, obstacle_right/left | valid && ready
//  cfg         | in  | reg_index, wdata                          | valid && ready
//
// One item per cycle while the result buffer has room; each item yields one registered result.
// All state updates in the transfer cycle; the result register is fed directly.
// A two-entry result buffer lets input keep flowing for one item during an output stall.
// cfg is always ready. rst_n is asynchronous and restores all reset values at once.
`timescale 1ns / 1ps

module servo_pwm_and_sensor_sampler_top
    import spss_pkg::*;
#(
    parameter int CHANNELS     = CHANNELS_DEF,
    parameter int SAMPLE_DEPTH = SAMPLE_DEPTH_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    spss_in_if.sink    item_in,
    spss_out_if.source result_out,
    spss_cfg_if.sink   cfg
);

    logic [7:0] ticks_reg;
    logic [7:0] slices_reg;
    logic [4:0] thresh_reg;

    logic [7:0]          width_reg [CHANNELS];
    logic [CHANNELS-1:0] line_reg;
    logic [CHANNELS-1:0] line_next;
    logic [7:0]          phase_reg;
    logic [7:0]          phase_next;
    logic [7:0]          slice_reg;
    logic [7:0]          slice_next;
    logic [7:0]          wait_reg;
    logic [7:0]          wait_next;

    logic       accept;
    logic       tick;
    logic       width_wr;
    logic [7:0] phase_inc;
    logic [7:0] slice_inc;
    logic       slice_wrap;
    logic       frame_wrap;
    logic       blocked_right;
    logic       blocked_left;
    out_item_t  result;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ticks_reg  <= TICKS_RESET;
            slices_reg <= SLICES_RESET;
            thresh_reg <= THRESH_RESET;
        end
        else if (cfg.valid)
        begin
            case (cfg.reg_index)
                REG_TICKS:  ticks_reg  <= cfg.wdata;
                REG_SLICES: slices_reg <= cfg.wdata;
                REG_THRESH: thresh_reg <= cfg.wdata[4:0];
                default:    ;
            endcase
        end
    end

    assign accept   = item_in.valid && item_in.ready;
    assign tick     = accept && (item_in.data.mode == MODE_TICK);
    assign width_wr = accept && (item_in.data.mode == MODE_WIDTH);

    // a period register of zero wraps on every advance
    assign phase_inc  = phase_reg + 8'd1;
    assign slice_inc  = slice_reg + 8'd1;
    assign slice_wrap = phase_inc >= ticks_reg;
    assign frame_wrap = slice_wrap && (slice_inc >= slices_reg);

    always_comb
    begin
        line_next  = line_reg;
        phase_next = phase_reg;
        slice_next = slice_reg;
        wait_next  = wait_reg;
        if (tick)
        begin
            if (slice_reg == 8'd0)
            begin
                for (int n = 0; n < CHANNELS; n++)
                begin
                    line_next[n] = phase_reg < width_reg[n];
                end
            end
            if (phase_reg == 8'd0 && wait_reg != 8'd0)
            begin
                wait_next = wait_reg - 8'd1;
            end
            phase_next = slice_wrap ? 8'd0 : phase_inc;
            if (slice_wrap)
            begin
                slice_next = frame_wrap ? 8'd0 : slice_inc;
            end
        end
        else if (accept && item_in.data.mode == MODE_WAIT)
        begin
            wait_next = item_in.data.wait_ticks;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_reg  <= '0;
            phase_reg <= '0;
            slice_reg <= '0;
            wait_reg  <= '0;
            for (int n = 0; n < CHANNELS; n++)
            begin
                width_reg[n] <= CENTER_WIDTH;
            end
        end
        else
        begin
            line_reg  <= line_next;
            phase_reg <= phase_next;
            slice_reg <= slice_next;
            wait_reg  <= wait_next;
            for (int n = 0; n < CHANNELS; n++)
            begin
                if (width_wr && ({1'b0, item_in.data.channel} == 5'(n)))
                begin
                    width_reg[n] <= item_in.data.pulse_width;
                end
            end
        end
    end

    spss_sensor_ring #(
        .DEPTH (SAMPLE_DEPTH)
    ) u_ring_right (
        .clk       (clk),
        .rst_n     (rst_n),
        .shift_en  (tick && frame_wrap),
        .level     (item_in.data.right_level),
        .threshold (thresh_reg),
        .blocked   (blocked_right)
    );

    spss_sensor_ring #(
        .DEPTH (SAMPLE_DEPTH)
    ) u_ring_left (
        .clk       (clk),
        .rst_n     (rst_n),
        .shift_en  (tick && frame_wrap),
        .level     (item_in.data.left_level),
        .threshold (thresh_reg),
        .blocked   (blocked_left)
    );

    for (genvar b = 0; b < PWM_W; b++)
    begin : g_lines
        if (b < CHANNELS)
        begin : g_used
            assign result.pwm_lines[b] = line_next[b];
        end
        else
        begin : g_unused
            assign result.pwm_lines[b] = 1'b0;
        end
    end

    assign result.wait_active    = wait_next != 8'd0;
    assign result.obstacle_right = blocked_right;
    assign result.obstacle_left  = blocked_left;

    spss_skid u_skid (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (item_in.valid),
        .push_data  (result),
        .push_ready (item_in.ready),
        .out_ch     (result_out)
    );

    a_frame_wrap_clears_slice: assert property (@(posedge clk) disable iff (!rst_n)
        (tick && frame_wrap) |=> (slice_reg == 8'd0 && phase_reg == 8'd0))
        else $error("slice counter not cleared on frame wrap");

    a_wait_counts_down: assert property (@(posedge clk) disable iff (!rst_n)
        (tick && phase_reg == 8'd0 && wait_reg != 8'd0) |=>
        (wait_reg == $past(wait_reg) - 8'd1))
        else $error("wait counter missed its slice decrement");

    a_result_follows_transfer: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> result_out.valid)
        else $error("no result pending after an input transfer");

    a_phase_held_without_tick: assert property (@(posedge clk) disable iff (!rst_n)
        !tick |=> $stable(phase_reg) && $stable(slice_reg) && $stable(line_reg))
        else $error("timing state moved without a tick");

endmodule

@@ dv/servo_pwm_and_sensor_sampler_top_tb.sv @@
// Testbench for servo_pwm_and_sensor_sampler_top: timer ticks, width writes and wait loads
// under several register settings, checked against a built-in predictor.
// Depends on spss_pkg, spss_if and the design files.
`timescale 1ns / 1ps

module servo_pwm_and_sensor_sampler_top_tb;
    import spss_pkg::*;

    localparam logic [1:0] MODE_SPARE = 2'd3;
    localparam int         HOLD_CYCLES = 80;
    localparam int         SETTLE_CYCLES = 5;

    class pwm_scoreboard;
        logic [7:0]       ticks_reg;
        logic [7:0]       slices_reg;
        logic [4:0]       thresh_reg;
        logic [7:0]       width_mem [CHANNELS_DEF];
        logic [PWM_W-1:0] lines;
        logic [7:0]       phase_cnt;
        logic [7:0]       slice_cnt;
        logic [7:0]       wait_left;
        bit               ring_r [SAMPLE_DEPTH_DEF];
        bit               ring_l [SAMPLE_DEPTH_DEF];
        int               ring_idx;
        out_item_t        expected_status [$];
        int               errors;

        function new();
            ticks_reg  = TICKS_RESET;
            slices_reg = SLICES_RESET;
            thresh_reg = THRESH_RESET;
            foreach (width_mem[n]) width_mem[n] = CENTER_WIDTH;
            lines     = '0;
            phase_cnt = '0;
            slice_cnt = '0;
            wait_left = '0;
            foreach (ring_r[i]) ring_r[i] = 1'b1;
            foreach (ring_l[i]) ring_l[i] = 1'b1;
            ring_idx = 0;
            errors   = 0;
        endfunction

        function void write_reg(logic [1:0] idx, logic [7:0] value);
            case (idx)
                REG_TICKS:  ticks_reg  = value;
                REG_SLICES: slices_reg = value;
                REG_THRESH: thresh_reg = value[4:0];
                default: ;
            endcase
        endfunction

        function bit blocked(bit ring [SAMPLE_DEPTH_DEF]);
            int zeros;
            zeros = 0;
            foreach (ring[i]) if (!ring[i]) zeros++;
            return zeros > int'(thresh_reg);
        endfunction

        function void advance_tick(bit right, bit left);
            if (slice_cnt == 8'd0)
                for (int n = 0; n < PWM_W; n++)
                    lines[n] = phase_cnt < width_mem[n];
            if (phase_cnt == 8'd0 && wait_left != 8'd0)
                wait_left = wait_left - 8'd1;
            phase_cnt = phase_cnt + 8'd1;
            if (phase_cnt >= ticks_reg) begin
                phase_cnt = '0;
                slice_cnt = slice_cnt + 8'd1;
                if (slice_cnt >= slices_reg) begin
                    slice_cnt = '0;
                    ring_r[ring_idx] = right;
                    ring_l[ring_idx] = left;
                    ring_idx = (ring_idx == SAMPLE_DEPTH_DEF - 1) ? 0 : ring_idx + 1;
                end
            end
        endfunction

        function void apply_item(in_item_t it);
            out_item_t r;
            case (it.mode)
                MODE_TICK:  advance_tick(it.right_level, it.left_level);
                MODE_WIDTH: if (it.channel < CHANNELS_DEF) width_mem[it.channel] = it.pulse_width;
                MODE_WAIT:  wait_left = it.wait_ticks;
                default: ;
            endcase
            r.pwm_lines      = lines;
            r.wait_active    = wait_left != 8'd0;
            r.obstacle_right = blocked(ring_r);
            r.obstacle_left  = blocked(ring_l);
            expected_status.push_back(r);
        endfunction

        function void check_result(out_item_t got);
            out_item_t exp;
            if (expected_status.size() == 0) begin
                $error("result with no expectation pending: %h", got);
                errors++;
                return;
            end
            exp = expected_status.pop_front();
            if (got.pwm_lines !== exp.pwm_lines) begin
                $error("pwm_lines: expected %h, got %h", exp.pwm_lines, got.pwm_lines);
                errors++;
            end
            if (got.wait_active !== exp.wait_active) begin
                $error("wait_active: expected %b, got %b", exp.wait_active, got.wait_active);
                errors++;
            end
            if (got.obstacle_right !== exp.obstacle_right) begin
                $error("obstacle_right: expected %b, got %b",
                       exp.obstacle_right, got.obstacle_right);
                errors++;
            end
            if (got.obstacle_left !== exp.obstacle_left) begin
                $error("obstacle_left: expected %b, got %b",
                       exp.obstacle_left, got.obstacle_left);
                errors++;
            end
        endfunction

        function int pending();
            return expected_status.size();
        endfunction
    endclass

    logic clk;
    logic rst_n;

    spss_in_if  item_if ();
    spss_out_if res_if ();
    spss_cfg_if cfg_if ();

    servo_pwm_and_sensor_sampler_top dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_in    (item_if),
        .result_out (res_if),
        .cfg        (cfg_if)
    );

    pwm_scoreboard sb = new();
    bit            bursts_on;
    bit            hold_req;
    int            zero_pct_r;
    int            zero_pct_l;

    initial clk = 1'b0;

    always #10 clk = ~clk;

    initial
    begin
        #10_000_000;
        $display("servo_pwm_and_sensor_sampler_top: mismatch");
        $finish;
    end

    always @(posedge clk)
    begin
        if (rst_n) begin
            if (cfg_if.valid && cfg_if.ready)
                sb.write_reg(cfg_if.reg_index, cfg_if.wdata);
            if (item_if.valid && item_if.ready)
                sb.apply_item(item_if.data);
            if (res_if.valid && res_if.ready)
                sb.check_result(res_if.data);
        end
    end

    // receiver: random stall bursts, plus one long hold-off on request
    initial
    begin
        int stall_left;
        stall_left = 0;
        res_if.ready = 1'b0;
        forever begin
            @(negedge clk);
            if (hold_req) begin
                stall_left = HOLD_CYCLES;
                hold_req = 1'b0;
            end else if (stall_left == 0 && bursts_on && $urandom_range(0, 15) == 0) begin
                stall_left = $urandom_range(1, 13);
            end
            if (stall_left > 0) begin
                res_if.ready <= 1'b0;
                stall_left--;
            end else begin
                res_if.ready <= 1'b1;
            end
        end
    end

    function automatic in_item_t mk(logic [1:0] mode, logic [3:0] ch, logic [7:0] pw,
                                    logic [7:0] wt, bit r, bit l);
        in_item_t it;
        it.mode        = mode;
        it.channel     = ch;
        it.pulse_width = pw;
        it.wait_ticks  = wt;
        it.right_level = r;
        it.left_level  = l;
        return it;
    endfunction

    function automatic in_item_t random_item(int ticks);
        in_item_t it;
        int       pick;
        pick = $urandom_range(0, 99);
        if (pick < 70)
            it.mode = MODE_TICK;
        else if (pick < 82)
            it.mode = MODE_WIDTH;
        else if (pick < 94)
            it.mode = MODE_WAIT;
        else
            it.mode = MODE_SPARE;
        it.channel     = 4'($urandom_range(0, 15));
        it.pulse_width = $urandom_range(0, 1) ? 8'($urandom_range(0, ticks + 1))
                                              : 8'($urandom_range(0, 255));
        it.wait_ticks  = $urandom_range(0, 1) ? 8'($urandom_range(0, 3))
                                              : 8'($urandom_range(0, 255));
        it.right_level = $urandom_range(0, 99) >= zero_pct_r;
        it.left_level  = $urandom_range(0, 99) >= zero_pct_l;
        return it;
    endfunction

    task automatic send_item(in_item_t it);
        @(negedge clk);
        item_if.valid <= 1'b1;
        item_if.data  <= it;
        do @(posedge clk); while (!item_if.ready);
    endtask

    task automatic idle_input(int n);
        repeat (n) begin
            @(negedge clk);
            item_if.valid <= 1'b0;
            item_if.data  <= in_item_t'(24'($urandom));
        end
    endtask

    task automatic write_cfg(logic [1:0] idx, logic [7:0] value);
        @(negedge clk);
        cfg_if.valid     <= 1'b1;
        cfg_if.reg_index <= idx;
        cfg_if.wdata     <= value;
        do @(posedge clk); while (!cfg_if.ready);
        @(negedge clk);
        cfg_if.valid <= 1'b0;
    endtask

    task automatic drain();
        idle_input(1);
        while (sb.pending() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic run_phase(logic [7:0] ticks, logic [7:0] slices, logic [4:0] thresh,
                             int n, int rz, int lz, bit idle, bit hold);
        drain();
        write_cfg(REG_TICKS, ticks);
        write_cfg(REG_SLICES, slices);
        write_cfg(REG_THRESH, {3'b000, thresh});
        zero_pct_r = rz;
        zero_pct_l = lz;
        bursts_on  = idle;
        if (hold)
            hold_req = 1'b1;
        repeat (n) begin
            if (idle && !hold && $urandom_range(0, 9) == 0)
                idle_input($urandom_range(1, 13));
            send_item(random_item(ticks));
        end
    endtask

    initial
    begin
        item_if.valid    = 1'b0;
        item_if.data     = '0;
        cfg_if.valid     = 1'b0;
        cfg_if.reg_index = '0;
        cfg_if.wdata     = '0;
        bursts_on        = 1'b1;
        hold_req         = 1'b0;
        zero_pct_r       = 50;
        zero_pct_l       = 50;
        rst_n            = 1'b0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed: every operation, field extremes, ignored channels, unused mode
        send_item(mk(MODE_TICK, 4'd0, 8'd0, 8'd0, 1'b0, 1'b0));
        send_item(mk(MODE_WIDTH, 4'd0, 8'd0, 8'd0, 1'b1, 1'b1));
        send_item(mk(MODE_WIDTH, 4'd12, 8'd255, 8'd255, 1'b0, 1'b1));
        send_item(mk(MODE_WIDTH, 4'd13, 8'hAA, 8'h55, 1'b1, 1'b0));
        send_item(mk(MODE_WIDTH, 4'd15, 8'h55, 8'hAA, 1'b0, 1'b0));
        send_item(mk(MODE_WIDTH, 4'd5, 8'd1, 8'd0, 1'b1, 1'b1));
        send_item(mk(MODE_TICK, 4'd15, 8'd255, 8'd255, 1'b1, 1'b1));
        send_item(mk(MODE_TICK, 4'd0, 8'd0, 8'd0, 1'b0, 1'b1));
        send_item(mk(MODE_WAIT, 4'd3, 8'd0, 8'd255, 1'b1, 1'b0));
        send_item(mk(MODE_TICK, 4'd0, 8'd0, 8'd0, 1'b1, 1'b1));
        send_item(mk(MODE_WAIT, 4'd0, 8'd0, 8'd0, 1'b0, 1'b0));
        send_item(mk(MODE_TICK, 4'd0, 8'd0, 8'd0, 1'b1, 1'b1));
        send_item(mk(MODE_SPARE, 4'd15, 8'd255, 8'd255, 1'b1, 1'b1));
        send_item(mk(MODE_SPARE, 4'd0, 8'd0, 8'd0, 1'b0, 1'b0));
        send_item(mk(MODE_WAIT, 4'd0, 8'd0, 8'd1, 1'b1, 1'b1));
        repeat (4)
            send_item(mk(MODE_TICK, 4'd0, 8'd0, 8'd0, 1'b0, 1'b0));
        send_item(mk(MODE_WIDTH, 4'd7, 8'd3, 8'd0, 1'b1, 1'b1));
        repeat (3)
            send_item(mk(MODE_TICK, 4'd0, 8'd0, 8'd0, 1'b1, 1'b1));

        run_phase(8'd1, 8'd1, 5'd0, 120, 50, 20, 1'b1, 1'b0);
        run_phase(8'd2, 8'd1, 5'd20, 150, 100, 90, 1'b1, 1'b0);
        run_phase(8'd0, 8'd0, 5'd10, 120, 60, 40, 1'b1, 1'b0);
        run_phase(8'd255, 8'd255, 5'd31, 80, 50, 50, 1'b1, 1'b0);
        // period lowered below the running counter, with a long output hold-off
        run_phase(8'd4, 8'd3, 5'd5, 100, 30, 70, 1'b1, 1'b1);
        run_phase(8'd7, 8'd1, 5'd1, 120, 20, 10, 1'b1, 1'b0);
        run_phase(TICKS_RESET, SLICES_RESET, THRESH_RESET, 100, 50, 50, 1'b1, 1'b0);
        run_phase(8'd1, 8'd2, 5'd3, 140, 40, 60, 1'b0, 1'b0);

        idle_input(1);
        while (sb.pending() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("servo_pwm_and_sensor_sampler_top: match");
        else
            $display("servo_pwm_and_sensor_sampler_top: mismatch");
        $finish;
    end

endmodule
